/* hw/rtl/assert_macros.svh */
// Assertion macros for the dispatcher RTL, included by the dispatcher core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("Assertion failed.");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed.");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/cald_pkg.sv */
// Package with the constants, codes and types of the load dispatcher.
`timescale 1ns / 1ps
package cald_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int IDX_W       = $clog2(MAX_WORKERS);
    localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
    localparam int ID_W        = 16;
    localparam int LOAD_W      = 16;
    localparam int CLS_W       = 2;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_ASSIGN = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [1:0] POL_RR   = 2'd0;
    localparam logic [1:0] POL_SPEC = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        M_RR   = 2'd0,
        M_ALL  = 2'd1,
        M_SPEC = 2'd2,
        M_FIND = 2'd3
    } t_mode;

    typedef struct packed {
        logic [LOAD_W-1:0] load;
        logic [CLS_W-1:0]  cls;
        logic              has_class;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef struct packed {
        t_mode            mode;
        logic [ID_W-1:0]  key;
        logic [IDX_W-1:0] ptr;
        logic [CLS_W-1:0] job_class;
        logic             found;
        t_entry           best;
    } t_cmp_ctl;

endpackage

/* hw/rtl/capability_aware_load_dispatcher_core.sv */
// Top level of the capability-aware load dispatcher: sequencer, state and output register.
// Add, kind 3 and any request on an empty table skip the scan. A query makes a find pass, an
// assign a pick pass then a find pass, a falling-back specialist assign a specialist pass,
// an all-worker pass and a find pass. Each pass reads one slot a cycle into the shared compare.
// One request at a time: the next is accepted from the cycle after the result is registered.
// Synchronous active-low reset clears the worker count, rotate pointer and handshake state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module capability_aware_load_dispatcher_core
    import cald_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // worker_id[15:0], has_class[16], worker_class[18:17],
                                    // job_class[20:19], policy[22:21], zero[23]
    input  logic [1:0]  i_s_tuser,  // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // chosen_id[15:0], load_value[31:16]
    output logic [1:0]  o_m_tuser   // status[1:0]
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic              r_dv, n_dv;
    logic              r_out_valid, n_out_valid;

    logic              r_is_assign, n_is_assign;
    logic [ID_W-1:0]   r_key, n_key;
    logic [CLS_W-1:0]  r_jc, n_jc;
    t_mode             r_mode, n_mode;
    logic [CNT_W-1:0]  r_issue, n_issue;
    logic [IDX_W-1:0]  r_didx, n_didx;
    logic              r_found, n_found;
    t_entry            r_best, n_best;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic [1:0]        r_res_status, n_res_status;
    logic [ID_W-1:0]   r_res_chosen, n_res_chosen;
    logic [LOAD_W-1:0] r_res_load, n_res_load;
    logic [1:0]        r_out_status, n_out_status;
    logic [ID_W-1:0]   r_out_chosen, n_out_chosen;
    logic [LOAD_W-1:0] r_out_load, n_out_load;

    logic              accept;
    logic              issue;
    logic              scan_end;
    logic              take;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    t_entry            rd_data;
    t_cmp_ctl          cmp_ctl;
    logic [CNT_W-1:0]  ptr_inc;
    logic [LOAD_W-1:0] new_load;
    logic [1:0]        in_kind;
    logic [ID_W-1:0]   in_id;
    logic              in_hc;
    logic [CLS_W-1:0]  in_wc;
    logic [CLS_W-1:0]  in_jc;
    logic [1:0]        in_pol;

    assign in_kind = i_s_tuser;
    assign in_id   = i_s_tdata[15:0];
    assign in_hc   = i_s_tdata[16];
    assign in_wc   = i_s_tdata[18:17];
    assign in_jc   = i_s_tdata[20:19];
    assign in_pol  = i_s_tdata[22:21];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = o_s_tready && i_s_tvalid;
    assign issue      = (r_state == S_SCAN) && (r_issue < r_count);
    assign scan_end   = (r_state == S_SCAN) && !issue && !r_dv;
    assign ptr_inc    = CNT_W'(r_ptr) + CNT_W'(1);
    assign new_load   = (r_best.load == {LOAD_W{1'b1}}) ? r_best.load
                                                        : r_best.load + LOAD_W'(1);

    assign cmp_ctl.mode      = r_mode;
    assign cmp_ctl.key       = r_key;
    assign cmp_ctl.ptr       = r_ptr;
    assign cmp_ctl.job_class = r_jc;
    assign cmp_ctl.found     = r_found;
    assign cmp_ctl.best      = r_best;

    cald_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (r_issue[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    cald_cmp u_cmp (
        .i_ctl      (cmp_ctl),
        .i_cand     (rd_data),
        .i_cand_idx (r_didx),
        .o_take     (take)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_dv         = 1'b0;
        n_out_valid  = r_out_valid;
        n_is_assign  = r_is_assign;
        n_key        = r_key;
        n_jc         = r_jc;
        n_mode       = r_mode;
        n_issue      = r_issue;
        n_didx       = r_didx;
        n_found      = r_found;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_res_status = r_res_status;
        n_res_chosen = r_res_chosen;
        n_res_load   = r_res_load;
        n_out_status = r_out_status;
        n_out_chosen = r_out_chosen;
        n_out_load   = r_out_load;
        wr_en        = 1'b0;
        wr_addr      = r_best_idx;
        wr_data      = r_best;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_is_assign  = (in_kind == KIND_ASSIGN);
                    n_key        = in_id;
                    n_jc         = in_jc;
                    n_res_status = ST_OK;
                    n_res_chosen = '0;
                    n_res_load   = '0;
                    n_issue      = '0;
                    n_found      = 1'b0;
                    n_state      = S_DONE;
                    if (in_kind == KIND_ADD) begin
                        if (r_count == CNT_W'(MAX_WORKERS)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            wr_en             = 1'b1;
                            wr_addr           = r_count[IDX_W-1:0];
                            wr_data.id        = in_id;
                            wr_data.has_class = in_hc;
                            wr_data.cls       = in_wc;
                            wr_data.load      = '0;
                            n_count           = r_count + CNT_W'(1);
                        end
                    end else if (in_kind == KIND_ASSIGN || in_kind == KIND_QUERY) begin
                        if (r_count == '0) begin
                            n_res_status = ST_NONE;
                        end else begin
                            n_state = S_SCAN;
                            if (in_kind == KIND_QUERY) begin
                                n_mode = M_FIND;
                            end else if (in_pol == POL_RR) begin
                                n_mode = M_RR;
                            end else if (in_pol == POL_SPEC) begin
                                n_mode = M_SPEC;
                            end else begin
                                n_mode = M_ALL;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_issue = r_issue + CNT_W'(1);
                    n_dv    = 1'b1;
                    n_didx  = r_issue[IDX_W-1:0];
                end
                if (r_dv && take) begin
                    n_found    = 1'b1;
                    n_best     = rd_data;
                    n_best_idx = r_didx;
                end
                if (scan_end) begin
                    n_issue = '0;
                    n_found = 1'b0;
                    unique case (r_mode)
                        M_RR: begin
                            n_ptr  = (ptr_inc == r_count) ? '0 : ptr_inc[IDX_W-1:0];
                            n_key  = r_best.id;
                            n_mode = M_FIND;
                        end
                        M_ALL: begin
                            n_key  = r_best.id;
                            n_mode = M_FIND;
                        end
                        M_SPEC: begin
                            if (r_found) begin
                                n_key  = r_best.id;
                                n_mode = M_FIND;
                            end else begin
                                n_mode = M_ALL;
                            end
                        end
                        M_FIND: begin
                            n_state = S_DONE;
                            if (r_is_assign) begin
                                wr_en        = 1'b1;
                                wr_data.load = new_load;
                                n_res_chosen = r_key;
                                n_res_load   = new_load;
                            end else if (r_found) begin
                                n_res_load = r_best.load;
                            end else begin
                                n_res_status = ST_NONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_chosen = r_res_chosen;
                    n_out_load   = r_res_load;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_assign  <= n_is_assign;
        r_key        <= n_key;
        r_jc         <= n_jc;
        r_mode       <= n_mode;
        r_issue      <= n_issue;
        r_didx       <= n_didx;
        r_found      <= n_found;
        r_best       <= n_best;
        r_best_idx   <= n_best_idx;
        r_res_status <= n_res_status;
        r_res_chosen <= n_res_chosen;
        r_res_load   <= n_res_load;
        r_out_status <= n_out_status;
        r_out_chosen <= n_out_chosen;
        r_out_load   <= n_out_load;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {r_out_load, r_out_chosen};

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_WORKERS))
    `ASSERT_ALWAYS(a_ptr_in_table, i_clk, i_rst_n, (r_count == '0) || (CNT_W'(r_ptr) < r_count))
    `ASSERT_ALWAYS(a_assign_finds_pick, i_clk, i_rst_n, !(scan_end && r_mode == M_FIND && r_is_assign) || r_found)
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_s_tready)

endmodule

/* hw/rtl/cald_table.sv */
// Worker table memory with one write port and one registered read port.
`timescale 1ns / 1ps
module cald_table
    import cald_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry r_mem [MAX_WORKERS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/cald_cmp.sv */
// Shared compare unit that decides whether a scanned slot replaces the current pick.
`timescale 1ns / 1ps
module cald_cmp
    import cald_pkg::*;
(
    input  t_cmp_ctl         i_ctl,
    input  t_entry           i_cand,
    input  logic [IDX_W-1:0] i_cand_idx,
    output logic             o_take
);

    logic better;
    logic class_match;

    // Lower load wins; equal loads go to the smaller id.
    assign better = (i_cand.load < i_ctl.best.load) ||
                    ((i_cand.load == i_ctl.best.load) && (i_cand.id < i_ctl.best.id));
    assign class_match = i_cand.has_class && (i_cand.cls == i_ctl.job_class);

    always_comb begin
        unique case (i_ctl.mode)
            M_RR:    o_take = (i_cand_idx == i_ctl.ptr);
            M_ALL:   o_take = !i_ctl.found || better;
            M_SPEC:  o_take = class_match && (!i_ctl.found || better);
            M_FIND:  o_take = !i_ctl.found && (i_cand.id == i_ctl.key);
            default: o_take = 1'b0;
        endcase
    end

endmodule
